// ===== design/cmkc_pkg.sv =====
// ----------------------------------------------------------------------------
// cmkc_pkg
// Types, constants and the per-tick cipher function for the MAC key
// candidate checker.
// ----------------------------------------------------------------------------
`default_nettype none

package cmkc_pkg;

  localparam int unsigned CHAL_BITS = 96;
  localparam int unsigned MAC_BITS  = 32;
  localparam int unsigned TICKS     = CHAL_BITS + MAC_BITS - 1;
  localparam int unsigned IDX_W     = 40;
  localparam int unsigned CFG_W     = 64;
  localparam int unsigned LOWK_W    = 24;

  localparam logic [1:0] REG_CHAL_LO = 2'd0;
  localparam logic [1:0] REG_CHAL_HI = 2'd1;
  localparam logic [1:0] REG_MAC     = 2'd2;
  localparam logic [1:0] REG_KEY_LO  = 2'd3;

  localparam logic [7:0]  INIT_XOR = 8'h4C;
  localparam logic [7:0]  INIT_L   = 8'hEC;
  localparam logic [7:0]  INIT_R   = 8'h21;
  localparam logic [7:0]  INIT_B   = 8'h4C;
  localparam logic [15:0] INIT_T   = 16'hE012;

  typedef logic [7:0][7:0] key_t;

  typedef struct packed {
    logic [7:0]  l;
    logic [7:0]  r;
    logic [7:0]  b;
    logic [15:0] t;
  } cstate_t;

  function automatic key_t build_key(input logic [IDX_W-1:0] idx,
                                     input logic [LOWK_W-1:0] lowk);
    key_t k;
    for (int j = 0; j < 8; j++) begin
      k[j] = {idx[5*(7-j) +: 5], lowk[3*j +: 3]};
    end
    return k;
  endfunction

  function automatic cstate_t init_state(input key_t k);
    cstate_t s;
    logic [7:0] k0;
    k0  = k[0] ^ INIT_XOR;
    s.l = k0 + INIT_L;
    s.r = k0 + INIT_R;
    s.b = INIT_B;
    s.t = INIT_T;
    return s;
  endfunction

  function automatic cstate_t tick(input cstate_t s, input key_t k, input logic y);
    cstate_t    n;
    logic       c0, c1, c2, c3, c4, c5, c6, c7;
    logic       tt, bt, z0, z1, z2;
    logic [7:0] v;
    c0 = s.r[7]; c1 = s.r[6]; c2 = s.r[5]; c3 = s.r[4];
    c4 = s.r[3]; c5 = s.r[2]; c6 = s.r[1]; c7 = s.r[0];
    tt = s.t[15] ^ s.t[14] ^ s.t[10] ^ s.t[8] ^ s.t[5] ^ s.t[4] ^ s.t[1] ^ s.t[0];
    bt = s.b[6] ^ s.b[5] ^ s.b[4] ^ s.b[0];
    n.t = {tt ^ c0 ^ c4, s.t[15:1]};
    n.b = {bt ^ c7, s.b[7:1]};
    z0 = (c0 & c2) ^ (c1 & ~c3) ^ (c2 | c4);
    z1 = (c0 | c2) ^ (c5 | c7) ^ c1 ^ c6 ^ tt ^ y;
    z2 = (c3 & ~c5) ^ (c4 & c6) ^ c7 ^ tt;
    v   = k[{z0, z1, z2}] ^ n.b;
    n.r = v + s.l;
    n.l = n.r + s.r;
    return n;
  endfunction

endpackage

`default_nettype wire

// ===== design/card_mac_key_candidate_check.sv =====
// ----------------------------------------------------------------------------
// card_mac_key_candidate_check
// Builds a key from a candidate index, runs the card cipher over the
// configured challenge and flags whether the produced MAC matches.
// ----------------------------------------------------------------------------
//  channel   direction  handshake           payload
//  in_       input      in_valid/in_ready   in_key_index[39:0]
//  out_      output     out_valid/out_ready out_mac_hit, out_tried_index[39:0]
//  cfg_      input      cfg_we              cfg_index[1:0], cfg_wdata[63:0]
//
//  one beat per cycle in and out while the skid is empty
//  one register stage for key build and init, then one stage per cipher tick
//  (127 ticks), then the output register; the tick's two 8-bit adds set depth
//  all stages advance together; a two-entry output (register plus skid) lets
//  the last stage drain while out_ready is low, and in_ready drops on skid full
//  rst_n clears valid bits and configuration; payload stages have no reset
// ----------------------------------------------------------------------------
`default_nettype none

module card_mac_key_candidate_check (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [cmkc_pkg::IDX_W-1:0]    in_key_index,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic                               out_mac_hit,
  output logic [cmkc_pkg::IDX_W-1:0]         out_tried_index,
  input  wire logic                          cfg_we,
  input  wire logic [1:0]                    cfg_index,
  input  wire logic [cmkc_pkg::CFG_W-1:0]    cfg_wdata
);

  localparam int unsigned NT = cmkc_pkg::TICKS;

  logic [63:0]                    chal_lo_r;
  logic [31:0]                    chal_hi_r;
  logic [31:0]                    mac_r;
  logic [cmkc_pkg::LOWK_W-1:0]    keylo_r;
  logic [cmkc_pkg::CHAL_BITS-1:0] chal;

  cmkc_pkg::cstate_t        st_r    [0:NT];
  cmkc_pkg::cstate_t        st_nxt  [0:NT];
  logic [cmkc_pkg::IDX_W-1:0] idx_r [0:NT];
  logic [cmkc_pkg::IDX_W-1:0] idx_nxt [0:NT];
  logic                     match_r   [0:NT];
  logic                     match_nxt [0:NT];
  logic [NT:0]              vld_r;
  logic [NT:0]              vld_nxt;

  logic                       en;
  logic                       fin_vld;
  logic                       fin_match;
  logic                       out_vld_r, out_match_r;
  logic [cmkc_pkg::IDX_W-1:0] out_idx_r;
  logic                       skid_vld_r, skid_match_r;
  logic [cmkc_pkg::IDX_W-1:0] skid_idx_r;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chal_lo_r <= '0;
      chal_hi_r <= '0;
      mac_r     <= '0;
      keylo_r   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        cmkc_pkg::REG_CHAL_LO: chal_lo_r <= cfg_wdata;
        cmkc_pkg::REG_CHAL_HI: chal_hi_r <= cfg_wdata[31:0];
        cmkc_pkg::REG_MAC:     mac_r     <= cfg_wdata[31:0];
        cmkc_pkg::REG_KEY_LO:  keylo_r   <= cfg_wdata[cmkc_pkg::LOWK_W-1:0];
        default: ;
      endcase
    end
  end

  assign chal = {chal_hi_r, chal_lo_r};

  assign en       = !skid_vld_r;
  assign in_ready = en;

  // key build and cipher init
  assign st_nxt[0]    = cmkc_pkg::init_state(cmkc_pkg::build_key(in_key_index, keylo_r));
  assign idx_nxt[0]   = in_key_index;
  assign match_nxt[0] = 1'b1;
  assign vld_nxt[0]   = in_valid;

  // one cipher tick per stage
  for (genvar s = 0; s < NT; s++) begin : g_tick
    logic y;
    logic ok;
    if (s < cmkc_pkg::CHAL_BITS) begin : g_chal
      assign y  = chal[s];
      assign ok = 1'b1;
    end else begin : g_mac
      assign y  = 1'b0;
      assign ok = (st_r[s].r[2] == mac_r[s-cmkc_pkg::CHAL_BITS]);
    end
    assign st_nxt[s+1]    = cmkc_pkg::tick(st_r[s],
                              cmkc_pkg::build_key(idx_r[s], keylo_r), y);
    assign idx_nxt[s+1]   = idx_r[s];
    assign match_nxt[s+1] = match_r[s] & ok;
    assign vld_nxt[s+1]   = vld_r[s];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i <= NT; i++) begin
        st_r[i]    <= st_nxt[i];
        idx_r[i]   <= idx_nxt[i];
        match_r[i] <= match_nxt[i];
      end
    end
  end

  // last mac bit is checked on the final stage
  assign fin_vld   = vld_r[NT];
  assign fin_match = match_r[NT] & (st_r[NT].r[2] == mac_r[cmkc_pkg::MAC_BITS-1]);

  // output register with skid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (!out_vld_r || out_ready) begin
      if (skid_vld_r) begin
        out_vld_r  <= 1'b1;
        skid_vld_r <= 1'b0;
      end else begin
        out_vld_r <= fin_vld;
      end
    end else if (en && fin_vld) begin
      skid_vld_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_vld_r || out_ready) begin
      if (skid_vld_r) begin
        out_match_r <= skid_match_r;
        out_idx_r   <= skid_idx_r;
      end else begin
        out_match_r <= fin_match;
        out_idx_r   <= idx_r[NT];
      end
    end else if (en && fin_vld) begin
      skid_match_r <= fin_match;
      skid_idx_r   <= idx_r[NT];
    end
  end

  assign out_valid       = out_vld_r;
  assign out_mac_hit     = out_match_r;
  assign out_tried_index = out_idx_r;

`ifndef ASSERT_OFF
  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_vld_r |-> out_vld_r)
    else $error("skid holds a beat while the output register is empty");

  a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
    skid_vld_r && out_ready |=> !skid_vld_r && out_vld_r)
    else $error("skid beat not moved to output");

  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    en && fin_vld && out_vld_r && !out_ready |=> skid_vld_r)
    else $error("final stage beat lost while output stalled");
`endif

endmodule

`default_nettype wire
